@@ hw/rtl/bda_pkg.sv @@
// Shared types, constants and helpers for the binary-to-decimal ASCII converter.
// No dependencies; imported by every module of the block.
package bda_pkg;

	localparam int VALUE_W = 16;
	localparam int DIGIT_W = 4;
	localparam int ASCII_W = 6;
	localparam int PLACE_W = 3;
	localparam int WEIGHT_W = 14;

	// Decimal places, ten thousands down to ones
	localparam logic [PLACE_W-1:0] PLACE_TENK = 3'd4;
	localparam logic [PLACE_W-1:0] PLACE_THOU = 3'd3;
	localparam logic [PLACE_W-1:0] PLACE_HUND = 3'd2;
	localparam logic [PLACE_W-1:0] PLACE_TENS = 3'd1;
	localparam logic [PLACE_W-1:0] PLACE_ONES = 3'd0;

	localparam logic [ASCII_W-1:0] ASCII_ZERO = 6'd48;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

	// Controller to datapath
	typedef struct packed {
		logic load;	// take a new value, start at the top place
		logic sub;	// subtract the place weight, bump the digit count
		logic put;	// digit done: emit if needed, move to next place
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic ge;		// remainder still holds the place weight
		logic last_place;	// working on the ones place
		logic need_emit;	// current digit goes out as a character
		logic out_free;		// output register can take a character
	} stat_t;

	function automatic logic [WEIGHT_W-1:0] place_weight(input logic [PLACE_W-1:0] place);
		logic [WEIGHT_W-1:0] w;
		case (place)
			PLACE_TENK: w = 14'd10000;
			PLACE_THOU: w = 14'd1000;
			PLACE_HUND: w = 14'd100;
			PLACE_TENS: w = 14'd10;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

@@ hw/rtl/bda_ctrl.sv @@
// Controller state machine for the binary-to-decimal ASCII converter.
// Depends on bda_pkg; drives commands into bda_datapath.
module bda_ctrl
	import bda_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_BUSY = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_BUSY;
				end
			end
			ST_BUSY: begin
				if (stat.ge) begin
					cmd.sub = 1'b1;
				end else if (!stat.need_emit || stat.out_free) begin
					cmd.put = 1'b1;
					if (stat.last_place) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hw/rtl/bda_datapath.sv @@
// Datapath: remainder, digit counter, place index and the output character register.
// Depends on bda_pkg; commanded by bda_ctrl.
module bda_datapath
	import bda_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [VALUE_W-1:0] in_value,
	input  cmd_t               cmd,
	output stat_t              stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ASCII_W-1:0] out_ascii,
	output logic               out_last
);

	logic [VALUE_W-1:0] rest_q;
	logic [DIGIT_W-1:0] cnt_q;
	logic [PLACE_W-1:0] place_q;
	logic               lead_q;
	logic               out_valid_q;
	logic [ASCII_W-1:0] out_ascii_q;
	logic               out_last_q;

	logic [VALUE_W-1:0] weight;
	logic [DIGIT_W-1:0] digit;
	logic               last_place;
	logic               emit;

	assign weight     = {{(VALUE_W-WEIGHT_W){1'b0}}, place_weight(place_q)};
	assign last_place = (place_q == PLACE_ONES);
	assign digit      = last_place ? rest_q[DIGIT_W-1:0] : cnt_q;
	// hundreds, tens and ones always go out; higher places once nonzero
	assign emit = (place_q <= PLACE_HUND) || (digit != '0) || lead_q;

	assign stat.ge         = !last_place && (rest_q >= weight);
	assign stat.last_place = last_place;
	assign stat.need_emit  = emit;
	assign stat.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			place_q <= PLACE_TENK;
			lead_q  <= 1'b0;
		end else if (cmd.load) begin
			cnt_q   <= '0;
			place_q <= PLACE_TENK;
			lead_q  <= 1'b0;
		end else if (cmd.sub) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.put) begin
			cnt_q   <= '0;
			lead_q  <= lead_q | emit;
			if (!last_place) begin
				place_q <= place_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rest_q <= in_value;
		end else if (cmd.sub) begin
			rest_q <= rest_q - weight;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.put && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put && emit) begin
			out_ascii_q <= ASCII_ZERO + {{(ASCII_W-DIGIT_W){1'b0}}, digit};
			out_last_q  <= last_place;
		end
	end

	assign out_valid = out_valid_q;
	assign out_ascii = out_ascii_q;
	assign out_last  = out_last_q;

	// digit counter never passes nine
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= DIGIT_MAX)
		else $error("digit count above nine");

	// a character is only written while the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.put && emit) |-> (!out_valid_q || out_ready))
		else $error("output character overwritten");

	// emitted characters are decimal digits
	a_ascii_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_ascii_q >= ASCII_ZERO && out_ascii_q <= ASCII_ZERO + 6'd9))
		else $error("output character not a decimal digit");

	// the ones place is always emitted and closes the number
	a_ones_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.put && last_place) |=> (out_valid_q && out_last_q))
		else $error("ones digit not emitted as last character");

endmodule

@@ hw/rtl/binary_to_decimal_ascii.sv @@
// Top level of the binary-to-decimal ASCII converter.
// Depends on bda_pkg, bda_ctrl and bda_datapath.
//
// Usage:
//   s_* takes one unsigned 16-bit number per transaction (s_tdata).
//   m_* returns the number as decimal ASCII characters, most significant
//   first, one character per transaction; m_tlast marks the ones digit.
//   Hundreds, tens and ones always appear; the ten-thousands digit only when
//   nonzero, the thousands digit when nonzero or after a ten-thousands digit.
// Operation:
//   Digits are peeled by repeated subtraction of 10000, 1000, 100 and 10 in
//   one shared subtractor, one subtraction per cycle. A number occupies the
//   block until its ones digit has gone to the output register, after which
//   s_tready rises again. Each character is written as soon as its digit
//   is counted and the output register is free.
//   One number is converted at a time.
// Stall:
//   Characters sit in a single output register; if m_tready is low the
//   conversion holds at the next digit to emit. The next number can be
//   accepted while the last character still waits.
// Reset:
//   arst_n clears the controller and the output valid; nothing is pending.
module binary_to_decimal_ascii
	import bda_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,	// [15:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,	// [5:0] ascii_digit, [7:6] zero
	output logic        m_tlast	// last_digit
);

	cmd_t               cmd;
	stat_t              stat;
	logic [ASCII_W-1:0] ascii;

	bda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bda_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_value  (s_tdata[VALUE_W-1:0]),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_ascii (ascii),
		.out_last  (m_tlast)
	);

	assign m_tdata = {{(8-ASCII_W){1'b0}}, ascii};

endmodule
